// ----- sv/ddio_pkg.sv -----
// Shared types, constants and tables for the differential-drive odometry block.
`default_nettype none
package ddio_pkg;

  // Configuration reset and defaults
  localparam logic [15:0] RADIUS_RST   = 16'd2163;
  localparam int          STEPS_DEF    = 16;
  localparam int          FRAC_DEF     = 16;

  // Datapath widths
  localparam int CW     = 36;  // CORDIC x/y
  localparam int ZW     = 34;  // CORDIC angle accumulator
  localparam int MA_W   = 48;  // multiplier A port
  localparam int MB_W   = 18;  // multiplier B port
  localparam int ACC_W  = 72;  // accumulator
  localparam int DIV_W  = 64;  // dividend magnitude
  localparam int DEN_W  = 24;  // divisor (elapsed time)
  localparam int TAB_IW = 5;   // arctangent table index

  // Angles and constants
  localparam logic [31:0]          BA_HALF    = 32'h8000_0000;
  localparam logic signed [ZW-1:0] BA_QUARTER = ZW'(64'sh4000_0000);
  localparam logic signed [CW-1:0] GAIN_Q30   = CW'(64'sd652032874);
  localparam logic signed [CW-1:0] DEN_BIAS   = CW'(64'sd134217728);
  // 10^6 = 15 * 2^16 + 16960
  localparam logic signed [MB_W-1:0] USEC_HI  = 18'sd15;
  localparam logic signed [MB_W-1:0] USEC_LO  = 18'sd16960;
  // 2*pi in Q28 = 25735 * 2^16 + 60753
  localparam logic signed [MB_W-1:0] TWOPI_HI = 18'sd25735;
  localparam logic signed [MB_W-1:0] TWOPI_LO = 18'sd60753;

  // Sequencer states
  typedef enum logic [4:0] {
    S_IDLE, S_Q1, S_Q2, S_Q3, S_Q4, S_ATAN, S_YAW, S_SC,
    S_XH, S_XU, S_YH, S_YU, S_LH, S_LD, S_RH, S_RU, S_LVW,
    S_AL, S_AH, S_AD, S_AVW, S_OUT
  } state_t;

  // Multiply-accumulate control
  typedef struct packed {
    logic en;   // update accumulator
    logic clr;  // start from zero
    logic sub;  // subtract the product
    logic sh;   // product weighted by 2^16
  } mac_op_t;

  // arctan(2^-i) as binary angle
  function automatic logic [31:0] atan_lut(input logic [TAB_IW-1:0] i);
    logic [31:0] r;
    case (i)
      5'd0:  r = 32'h20000000;
      5'd1:  r = 32'h12E4051D;
      5'd2:  r = 32'h09FB385B;
      5'd3:  r = 32'h051111D4;
      5'd4:  r = 32'h028B0D43;
      5'd5:  r = 32'h0145D7E1;
      5'd6:  r = 32'h00A2F61E;
      5'd7:  r = 32'h00517C55;
      5'd8:  r = 32'h0028BE53;
      5'd9:  r = 32'h00145F2E;
      5'd10: r = 32'h000A2F98;
      5'd11: r = 32'h000517CC;
      5'd12: r = 32'h00028BE6;
      5'd13: r = 32'h000145F3;
      5'd14: r = 32'h0000A2F9;
      5'd15: r = 32'h0000517C;
      5'd16: r = 32'h000028BE;
      5'd17: r = 32'h0000145F;
      5'd18: r = 32'h00000A2F;
      5'd19: r = 32'h00000517;
      5'd20: r = 32'h0000028B;
      5'd21: r = 32'h00000145;
      5'd22: r = 32'h000000A2;
      5'd23: r = 32'h00000051;
      5'd24: r = 32'h00000028;
      5'd25: r = 32'h00000014;
      5'd26: r = 32'h0000000A;
      5'd27: r = 32'h00000005;
      5'd28: r = 32'h00000002;
      5'd29: r = 32'h00000001;
      default: r = 32'h00000000;
    endcase
    return r;
  endfunction

  // Saturate a wide signed value to 32 bits
  function automatic logic [31:0] sat32(input logic signed [ACC_W-1:0] v);
    logic [31:0] r;
    if (v > ACC_W'(64'sh7FFF_FFFF)) r = 32'h7FFF_FFFF;
    else if (v < -ACC_W'(64'sh8000_0000)) r = 32'h8000_0000;
    else r = v[31:0];
    return r;
  endfunction

endpackage
`default_nettype wire

// ----- sv/ddio_if.sv -----
// Channel interfaces: input sample, result and configuration write.
`default_nettype none
interface ddio_sample_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] wheel_left_pos;
  logic signed [31:0] wheel_right_pos;
  logic               left_valid;
  logic               right_valid;
  logic signed [15:0] quat_w;
  logic signed [15:0] quat_x;
  logic signed [15:0] quat_y;
  logic signed [15:0] quat_z;
  logic [23:0]        elapsed_us;
  modport source (output valid, wheel_left_pos, wheel_right_pos, left_valid, right_valid,
                  quat_w, quat_x, quat_y, quat_z, elapsed_us, input ready);
  modport sink   (input valid, wheel_left_pos, wheel_right_pos, left_valid, right_valid,
                  quat_w, quat_x, quat_y, quat_z, elapsed_us, output ready);
endinterface

interface ddio_result_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] pos_x_out;
  logic signed [31:0] pos_y_out;
  logic [31:0]        heading_out;
  logic signed [31:0] lin_vel;
  logic signed [31:0] ang_vel;
  logic               updated;
  modport source (output valid, pos_x_out, pos_y_out, heading_out, lin_vel, ang_vel,
                  updated, input ready);
  modport sink   (input valid, pos_x_out, pos_y_out, heading_out, lin_vel, ang_vel,
                  updated, output ready);
endinterface

interface ddio_cfg_if;
  logic        valid;
  logic        ready;
  logic [15:0] data;
  modport source (output valid, data, input ready);
  modport sink   (input valid, data, output ready);
endinterface
`default_nettype wire

// ----- sv/diff_drive_imu_odometry.sv -----
// Differential-drive odometry with IMU yaw: sequencer over shared MAC, CORDIC and divider.
// A sample passes the quaternion products, a CORDIC vectoring pass for yaw, a CORDIC rotation
//   pass, the position and rate products and two 64-step divisions before its result is registered.
// A new sample is accepted only in the idle state, once the previous result has been registered;
//   a sample with zero elapsed time goes straight to the output state.
// Synchronous active-high reset clears pose, heading, wheel/yaw history and sets the radius
//   to its default; a finished result may wait in the output register while a new beat enters.
`default_nettype none
module diff_drive_imu_odometry
  import ddio_pkg::*;
#(
  parameter int CORDIC_STEPS = STEPS_DEF,
  parameter int FRAC_BITS    = FRAC_DEF
) (
  input  wire logic    clk,
  input  wire logic    rst,
  ddio_sample_if.sink  sample,
  ddio_result_if.source result,
  ddio_cfg_if.sink     cfg
);

  localparam int RAD_SH = 44 - FRAC_BITS;

  state_t state, state_next;

  // configuration and state
  logic [15:0]        radius;
  logic [31:0]        last_left, last_right, last_yaw, heading;
  logic signed [31:0] pos_x, pos_y;

  // per-sample working registers
  logic signed [15:0]   qx, qy, qz;
  logic [23:0]          el;
  logic signed [32:0]   wsum;
  logic signed [32:0]   num;
  logic signed [33:0]   ds;
  logic [31:0]          yaw;
  logic signed [31:0]   dth;
  logic signed [MA_W-1:0] rad;
  logic                 div_neg;
  logic [31:0]          lv, av;
  logic                 upd;

  // unit connections
  mac_op_t                 mop;
  logic signed [MA_W-1:0]  ma;
  logic signed [MB_W-1:0]  mb;
  logic signed [ACC_W-1:0] acc;
  logic                    cor_start, cor_rot, cor_done;
  logic signed [CW-1:0]    cor_xin, cor_yin, cor_x, cor_y;
  logic [31:0]             cor_ang, cor_z;
  logic                    div_start, div_done;
  logic [DIV_W-1:0]        div_num, div_q;
  logic signed [DIV_W:0]   q_s;
  logic signed [ACC_W-1:0] pos_sum;
  logic signed [31:0]      dl, dr;
  logic                    accept, out_free;

  assign accept     = sample.valid && sample.ready;
  assign out_free   = !result.valid || result.ready;
  assign sample.ready = (state == S_IDLE);
  assign cfg.ready    = 1'b1;

  ddio_mac u_mac (.clk, .op(mop), .a(ma), .b(mb), .acc);

  ddio_cordic #(.STEPS(CORDIC_STEPS)) u_cordic (
    .clk, .rst, .start(cor_start), .rot(cor_rot), .x_in(cor_xin), .y_in(cor_yin),
    .ang_in(cor_ang), .done(cor_done), .x_out(cor_x), .y_out(cor_y), .z_out(cor_z)
  );

  ddio_div u_div (
    .clk, .rst, .start(div_start), .num(div_num), .den(el), .done(div_done), .quo(div_q)
  );

  // wrapped wheel deltas, invalid wheels count as zero
  always_comb begin
    dl      = sample.left_valid  ? signed'(sample.wheel_left_pos  - last_left)  : 32'sd0;
    dr      = sample.right_valid ? signed'(sample.wheel_right_pos - last_right) : 32'sd0;
    div_num = acc[ACC_W-1] ? DIV_W'(-acc) : DIV_W'(acc);
    q_s     = div_neg ? -signed'({1'b0, div_q}) : signed'({1'b0, div_q});
    pos_sum = '0;
  end

  // state register
  always_ff @(posedge clk) begin
    if (rst) state <= S_IDLE;
    else     state <= state_next;
  end

  // sequencer: next state and unit commands
  always_comb begin
    state_next = state;
    mop        = '0;
    ma         = '0;
    mb         = '0;
    cor_start  = 1'b0;
    cor_rot    = 1'b0;
    cor_xin    = CW'(acc) + DEN_BIAS;
    cor_yin    = CW'(num);
    cor_ang    = heading + 32'(dth >>> 1);
    div_start  = 1'b0;
    case (state)
      S_IDLE: begin
        if (accept) begin
          if (sample.elapsed_us == '0) begin
            state_next = S_OUT;
          end else begin
            mop        = '{en: 1'b1, clr: 1'b1, sub: 1'b0, sh: 1'b0};
            ma         = MA_W'(sample.quat_w);
            mb         = MB_W'(sample.quat_z);
            state_next = S_Q1;
          end
        end
      end
      S_Q1: begin
        mop = '{en: 1'b1, clr: 1'b0, sub: 1'b0, sh: 1'b0};
        ma  = MA_W'(qx);
        mb  = MB_W'(qy);
        state_next = S_Q2;
      end
      S_Q2: begin
        mop = '{en: 1'b1, clr: 1'b1, sub: 1'b1, sh: 1'b0};
        ma  = MA_W'(qy);
        mb  = MB_W'(qy);
        state_next = S_Q3;
      end
      S_Q3: begin
        mop = '{en: 1'b1, clr: 1'b0, sub: 1'b1, sh: 1'b0};
        ma  = MA_W'(qz);
        mb  = MB_W'(qz);
        state_next = S_Q4;
      end
      S_Q4: begin
        cor_start  = 1'b1;
        mop        = '{en: 1'b1, clr: 1'b1, sub: 1'b0, sh: 1'b0};
        ma         = MA_W'(wsum);
        mb         = MB_W'({2'b00, radius});
        state_next = S_ATAN;
      end
      S_ATAN: if (cor_done) state_next = S_YAW;
      S_YAW: begin
        cor_start  = 1'b1;
        cor_rot    = 1'b1;
        state_next = S_SC;
      end
      S_SC: begin
        if (cor_done) begin
          mop        = '{en: 1'b1, clr: 1'b1, sub: 1'b0, sh: 1'b0};
          ma         = MA_W'(ds);
          mb         = MB_W'({2'b00, cor_x[15:0]});
          state_next = S_XH;
        end
      end
      S_XH: begin
        mop = '{en: 1'b1, clr: 1'b0, sub: 1'b0, sh: 1'b1};
        ma  = MA_W'(ds);
        mb  = cor_x[33:16];
        state_next = S_XU;
      end
      S_XU: begin
        mop = '{en: 1'b1, clr: 1'b1, sub: 1'b0, sh: 1'b0};
        ma  = MA_W'(ds);
        mb  = MB_W'({2'b00, cor_y[15:0]});
        state_next = S_YH;
      end
      S_YH: begin
        mop = '{en: 1'b1, clr: 1'b0, sub: 1'b0, sh: 1'b1};
        ma  = MA_W'(ds);
        mb  = cor_y[33:16];
        state_next = S_YU;
      end
      S_YU: begin
        mop = '{en: 1'b1, clr: 1'b1, sub: 1'b0, sh: 1'b0};
        ma  = MA_W'(ds);
        mb  = USEC_LO;
        state_next = S_LH;
      end
      S_LH: begin
        mop = '{en: 1'b1, clr: 1'b0, sub: 1'b0, sh: 1'b1};
        ma  = MA_W'(ds);
        mb  = USEC_HI;
        state_next = S_LD;
      end
      S_LD: begin
        div_start = 1'b1;
        mop = '{en: 1'b1, clr: 1'b1, sub: 1'b0, sh: 1'b0};
        ma  = MA_W'(dth);
        mb  = TWOPI_LO;
        state_next = S_RH;
      end
      S_RH: begin
        mop = '{en: 1'b1, clr: 1'b0, sub: 1'b0, sh: 1'b1};
        ma  = MA_W'(dth);
        mb  = TWOPI_HI;
        state_next = S_RU;
      end
      S_RU: state_next = S_LVW;
      S_LVW: if (div_done) state_next = S_AL;
      S_AL: begin
        mop = '{en: 1'b1, clr: 1'b1, sub: 1'b0, sh: 1'b0};
        ma  = rad;
        mb  = USEC_LO;
        state_next = S_AH;
      end
      S_AH: begin
        mop = '{en: 1'b1, clr: 1'b0, sub: 1'b0, sh: 1'b1};
        ma  = rad;
        mb  = USEC_HI;
        state_next = S_AD;
      end
      S_AD: begin
        div_start  = 1'b1;
        state_next = S_AVW;
      end
      S_AVW: if (div_done) state_next = S_OUT;
      S_OUT: if (out_free) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  // configuration register
  always_ff @(posedge clk) begin
    if (rst) radius <= RADIUS_RST;
    else if (cfg.valid && cfg.ready) radius <= cfg.data;
  end

  // odometry state
  always_ff @(posedge clk) begin
    if (rst) begin
      last_left  <= '0;
      last_right <= '0;
      last_yaw   <= '0;
      heading    <= '0;
      pos_x      <= '0;
      pos_y      <= '0;
    end else begin
      if (accept) begin
        last_left  <= sample.wheel_left_pos;
        last_right <= sample.wheel_right_pos;
      end
      if (state == S_XU) pos_x <= sat32(ACC_W'(pos_x) + (acc >>> 30));
      if (state == S_YU) begin
        pos_y    <= sat32(ACC_W'(pos_y) + (acc >>> 30));
        heading  <= heading + dth;
        last_yaw <= yaw;
      end
    end
  end

  // working registers
  always_ff @(posedge clk) begin
    if (accept) begin
      qx   <= sample.quat_x;
      qy   <= sample.quat_y;
      qz   <= sample.quat_z;
      el   <= sample.elapsed_us;
      wsum <= 33'(dl) + 33'(dr);
      upd  <= (sample.elapsed_us != '0);
      lv   <= '0;
      av   <= '0;
    end
    if (state == S_Q2) num <= acc[32:0];
    if (state == S_ATAN) begin
      ds <= 34'(acc >>> 17);
      if (cor_done) begin
        yaw <= cor_z;
        dth <= signed'(cor_z - last_yaw);
      end
    end
    if (state == S_LD || state == S_AD) div_neg <= acc[ACC_W-1];
    if (state == S_RU) rad <= MA_W'(acc >>> RAD_SH);
    if (state == S_LVW && div_done) lv <= sat32(ACC_W'(q_s) + pos_sum);
    if (state == S_AVW && div_done) av <= sat32(ACC_W'(q_s >>> 16));
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      result.valid <= 1'b0;
    end else if (state == S_OUT && out_free) begin
      result.valid <= 1'b1;
    end else if (result.ready) begin
      result.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_OUT && out_free) begin
      result.pos_x_out   <= pos_x;
      result.pos_y_out   <= pos_y;
      result.heading_out <= heading;
      result.lin_vel     <= lv;
      result.ang_vel     <= av;
      result.updated     <= upd;
    end
  end

`ifndef SYNTHESIS
  a_cordic_done_expected: assert property (@(posedge clk) disable iff (rst)
    cor_done |-> (state == S_ATAN || state == S_SC))
    else $error("CORDIC finished outside a wait state");
  a_div_done_expected: assert property (@(posedge clk) disable iff (rst)
    div_done |-> (state == S_LVW || state == S_AVW))
    else $error("divider finished outside a wait state");
  a_zero_time_short: assert property (@(posedge clk) disable iff (rst)
    (accept && sample.elapsed_us == '0) |=> state == S_OUT)
    else $error("zero elapsed time beat did not go straight to output");
  a_result_from_out: assert property (@(posedge clk) disable iff (rst)
    $rose(result.valid) |-> $past(state) == S_OUT)
    else $error("result raised without passing the output state");
`endif

endmodule
`default_nettype wire

// ----- sv/ddio_mac.sv -----
// Shared signed multiply-accumulate unit.
`default_nettype none
module ddio_mac
  import ddio_pkg::*;
(
  input  wire logic                    clk,
  input  wire mac_op_t                 op,
  input  wire logic signed [MA_W-1:0]  a,
  input  wire logic signed [MB_W-1:0]  b,
  output logic signed [ACC_W-1:0]      acc
);

  logic signed [MA_W+MB_W-1:0] prod;
  logic signed [ACC_W-1:0]     term;
  logic signed [ACC_W-1:0]     base;

  // one product, optionally weighted by 2^16, added to or taken from the sum
  always_comb begin
    prod = a * b;
    term = op.sh ? (ACC_W'(prod) <<< 16) : ACC_W'(prod);
    base = op.clr ? '0 : acc;
  end

  always_ff @(posedge clk) begin
    if (op.en) begin
      acc <= op.sub ? base - term : base + term;
    end
  end

endmodule
`default_nettype wire

// ----- sv/ddio_cordic.sv -----
// Iterative CORDIC, vectoring (atan2) or rotation (cos/sin) mode.
`default_nettype none
module ddio_cordic
  import ddio_pkg::*;
#(
  parameter int STEPS = STEPS_DEF
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  start,
  input  wire logic                  rot,
  input  wire logic signed [CW-1:0]  x_in,
  input  wire logic signed [CW-1:0]  y_in,
  input  wire logic [31:0]           ang_in,
  output logic                       done,
  output logic signed [CW-1:0]       x_out,
  output logic signed [CW-1:0]       y_out,
  output logic [31:0]                z_out
);

  localparam int CNT_W = $clog2(STEPS + 1);

  logic                busy;
  logic [CNT_W-1:0]    cnt;
  logic                mode_rot;
  logic                flip;
  logic                zero;
  logic signed [CW-1:0] x, y;
  logic signed [ZW-1:0] z;
  logic signed [CW-1:0] xs, ys;
  logic signed [ZW-1:0] a;
  logic signed [ZW-1:0] za;
  logic signed [ZW-1:0] zf;
  logic                 sig;

  // one micro-rotation per cycle
  always_comb begin
    xs  = x >>> cnt;
    ys  = y >>> cnt;
    a   = ZW'(atan_lut(TAB_IW'(cnt)));
    sig = mode_rot ? (z >= 0) : (y <= 0);
    za  = ZW'(signed'(ang_in));
    zf  = ZW'(signed'(ang_in - BA_HALF));
  end

  // control
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == CNT_W'(STEPS - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    if (start) begin
      mode_rot <= rot;
      if (rot) begin
        x    <= GAIN_Q30;
        y    <= '0;
        zero <= 1'b0;
        if (za > BA_QUARTER || za < -BA_QUARTER) begin
          z    <= zf;
          flip <= 1'b1;
        end else begin
          z    <= za;
          flip <= 1'b0;
        end
      end else begin
        flip <= 1'b0;
        zero <= (x_in == 0) && (y_in == 0);
        if (x_in < 0) begin
          x <= -x_in;
          y <= -y_in;
          z <= ZW'(BA_HALF);
        end else begin
          x <= x_in;
          y <= y_in;
          z <= '0;
        end
      end
    end else if (busy) begin
      if (sig) begin
        x <= x - ys;
        y <= y + xs;
        z <= z - a;
      end else begin
        x <= x + ys;
        y <= y - xs;
        z <= z + a;
      end
    end
  end

  // results: fold back half-turn, degenerate vector gives zero angle
  always_comb begin
    x_out = flip ? -x : x;
    y_out = flip ? -y : y;
    z_out = zero ? 32'd0 : z[31:0];
  end

endmodule
`default_nettype wire

// ----- sv/ddio_div.sv -----
// Restoring unsigned divider, one quotient bit per cycle.
`default_nettype none
module ddio_div
  import ddio_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              start,
  input  wire logic [DIV_W-1:0]  num,
  input  wire logic [DEN_W-1:0]  den,
  output logic                   done,
  output logic [DIV_W-1:0]       quo
);

  localparam int CNT_W = $clog2(DIV_W + 1);

  logic             busy;
  logic [CNT_W-1:0] cnt;
  logic [DEN_W-1:0] d;
  logic [DEN_W-1:0] rem;
  logic [DEN_W:0]   trial;
  logic             ge;

  // shift in the next dividend bit and try the subtraction
  always_comb begin
    trial = {rem, quo[DIV_W-1]};
    ge    = trial >= {1'b0, d};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == CNT_W'(DIV_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quo <= num;
      rem <= '0;
      d   <= den;
    end else if (busy) begin
      rem <= ge ? DEN_W'(trial - {1'b0, d}) : trial[DEN_W-1:0];
      quo <= {quo[DIV_W-2:0], ge};
    end
  end

endmodule
`default_nettype wire

// ----- tb/sv/tb_top.sv -----
// Self-checking testbench for the differential-drive odometry block.
`default_nettype none
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import ddio_pkg::*;

  localparam int  N_ITEMS   = 650;
  localparam int  SETTLE    = 250;
  localparam int  HOLD_LEN  = 1500;
  localparam longint LIMIT  = 2000000;
  localparam int  STEPS     = 16;
  localparam longint GAIN   = 652032874;
  localparam longint TWOPI  = 1686629713;
  localparam longint USEC   = 1000000;
  localparam longint QUART  = 64'h4000_0000;

  // idling modes of the four phases
  typedef enum logic [1:0] {IDLE_NONE, IDLE_SRC, IDLE_SNK, IDLE_BOTH} idle_mode_t;

  typedef struct {
    logic [31:0] left, right;
    logic        lv, rv;
    logic [15:0] qw, qx, qy, qz;
    logic [23:0] el;
  } sample_t;

  typedef struct {
    logic [31:0] px, py, hd, lin, ang;
    logic        upd;
  } pose_t;

  logic clk, rst;
  ddio_sample_if sample_ch();
  ddio_result_if result_ch();
  ddio_cfg_if    cfg_ch();

  diff_drive_imu_odometry u_dut (
    .clk(clk), .rst(rst), .sample(sample_ch), .result(result_ch), .cfg(cfg_ch)
  );

  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  // arctan(2^-i) as binary angle
  logic [31:0] arctan_bam [0:15] = '{
    32'h20000000, 32'h12E4051D, 32'h09FB385B, 32'h051111D4, 32'h028B0D43,
    32'h0145D7E1, 32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2E,
    32'h000A2F98, 32'h000517CC, 32'h00028BE6, 32'h000145F3, 32'h0000A2F9,
    32'h0000517C};

  // predictor state
  logic [15:0] radius;
  logic [31:0] prev_left, prev_right, prev_yaw, head;
  logic signed [31:0] x_pos, y_pos;

  sample_t sample_q [$];
  pose_t   pose_q [$];
  idle_mode_t idle_mode;
  logic    hold_rx, pressure_go;
  int      errors, results_seen, zero_dt_seen;
  longint  cycles;

  function automatic logic signed [31:0] clamp32(longint v);
    if (v > 64'sh7FFF_FFFF) return 32'sh7FFF_FFFF;
    if (v < -64'sh8000_0000) return 32'sh8000_0000;
    return v[31:0];
  endfunction

  function automatic logic [31:0] yaw_of(longint yv, longint xv);
    logic [31:0] z;
    longint xs, ys;
    z = '0;
    if (xv == 0 && yv == 0) return '0;
    if (xv < 0) begin
      xv = -xv;
      yv = -yv;
      z = BA_HALF;
    end
    for (int i = 0; i < STEPS; i++) begin
      xs = xv >>> i;
      ys = yv >>> i;
      if (yv > 0) begin
        xv += ys; yv -= xs; z += arctan_bam[i];
      end else begin
        xv -= ys; yv += xs; z -= arctan_bam[i];
      end
    end
    return z;
  endfunction

  function automatic void rotate(logic [31:0] ang, output longint c, output longint s);
    longint z, xv, yv, xs, ys;
    logic flip;
    z = longint'($signed(ang));
    xv = GAIN;
    yv = 0;
    flip = 1'b0;
    if (z > QUART || z < -QUART) begin
      z = longint'($signed(ang - BA_HALF));
      flip = 1'b1;
    end
    for (int i = 0; i < STEPS; i++) begin
      xs = xv >>> i;
      ys = yv >>> i;
      if (z >= 0) begin
        xv -= ys; yv += xs; z -= longint'(arctan_bam[i]);
      end else begin
        xv += ys; yv -= xs; z += longint'(arctan_bam[i]);
      end
    end
    c = flip ? -xv : xv;
    s = flip ? -yv : yv;
  endfunction

  // advance the pose by one sample and return the expected result
  function automatic pose_t odometry_step(sample_t smp);
    pose_t r;
    longint dl, dr, ds, num, den, dth, c, s, rad, lin, ang;
    logic [31:0] yaw, mid;
    dl = smp.lv ? longint'($signed(smp.left - prev_left)) : 0;
    dr = smp.rv ? longint'($signed(smp.right - prev_right)) : 0;
    prev_left = smp.left;
    prev_right = smp.right;
    lin = 0;
    ang = 0;
    r.upd = 1'b0;
    if (smp.el != 0) begin
      ds  = ((dl + dr) * longint'(radius)) >>> 17;
      num = longint'($signed(smp.qw)) * longint'($signed(smp.qz))
          + longint'($signed(smp.qx)) * longint'($signed(smp.qy));
      den = (64'sd1 <<< 27) - longint'($signed(smp.qy)) * longint'($signed(smp.qy))
          - longint'($signed(smp.qz)) * longint'($signed(smp.qz));
      yaw = yaw_of(num, den);
      dth = longint'($signed(yaw - prev_yaw));
      mid = head + 32'(dth >>> 1);
      rotate(mid, c, s);
      x_pos = clamp32(longint'(x_pos) + ((ds * c) >>> 30));
      y_pos = clamp32(longint'(y_pos) + ((ds * s) >>> 30));
      head += 32'(dth);
      prev_yaw = yaw;
      lin = (ds * USEC) / longint'(smp.el);
      rad = (dth * TWOPI) >>> 28;
      ang = ((rad * USEC) / longint'(smp.el)) >>> 16;
      r.upd = 1'b1;
    end
    r.px = x_pos;
    r.py = y_pos;
    r.hd = head;
    r.lin = clamp32(lin);
    r.ang = clamp32(ang);
    return r;
  endfunction

  // source side: present pending samples, predict on each accepted beat
  sample_t cur;
  always @(posedge clk) begin
    if (rst) begin
      sample_ch.valid <= 1'b0;
    end else if (!sample_ch.valid || sample_ch.ready) begin
      if (sample_ch.valid) pose_q.push_back(odometry_step(cur));
      if (sample_q.size() > 0 &&
          !((idle_mode == IDLE_SRC || idle_mode == IDLE_BOTH) &&
            $urandom_range(99) < (idle_mode == IDLE_SRC ? 80 : 29))) begin
        cur = sample_q.pop_front();
        sample_ch.valid           <= 1'b1;
        sample_ch.wheel_left_pos  <= cur.left;
        sample_ch.wheel_right_pos <= cur.right;
        sample_ch.left_valid      <= cur.lv;
        sample_ch.right_valid     <= cur.rv;
        sample_ch.quat_w          <= cur.qw;
        sample_ch.quat_x          <= cur.qx;
        sample_ch.quat_y          <= cur.qy;
        sample_ch.quat_z          <= cur.qz;
        sample_ch.elapsed_us      <= cur.el;
      end else begin
        sample_ch.valid <= 1'b0;
      end
    end
  end

  // sink side: check each result beat against the oldest prediction
  always @(posedge clk) begin
    pose_t e;
    if (!rst && result_ch.valid && result_ch.ready) begin
      results_seen++;
      if (pose_q.size() == 0) begin
        errors++;
        if (errors <= 10) $display("ERROR: result beat with no prediction pending");
      end else begin
        e = pose_q.pop_front();
        if (!e.upd) zero_dt_seen++;
        if (result_ch.pos_x_out !== e.px || result_ch.pos_y_out !== e.py ||
            result_ch.heading_out !== e.hd || result_ch.lin_vel !== e.lin ||
            result_ch.ang_vel !== e.ang || result_ch.updated !== e.upd) begin
          errors++;
          if (errors <= 10)
            $display("ERROR: beat %0d exp x=%h y=%h hd=%h lv=%h av=%h u=%b",
                     results_seen, e.px, e.py, e.hd, e.lin, e.ang, e.upd,
                     "\n       got x=%h y=%h hd=%h lv=%h av=%h u=%b",
                     result_ch.pos_x_out, result_ch.pos_y_out, result_ch.heading_out,
                     result_ch.lin_vel, result_ch.ang_vel, result_ch.updated);
        end
      end
    end
    if (rst || hold_rx) result_ch.ready <= 1'b0;
    else if (idle_mode == IDLE_SNK) result_ch.ready <= ($urandom_range(99) >= 80);
    else if (idle_mode == IDLE_BOTH) result_ch.ready <= ($urandom_range(99) >= 29);
    else result_ch.ready <= 1'b1;
  end

  // long receiver hold-off so the block backs up onto its input
  initial begin
    hold_rx = 1'b0;
    wait (pressure_go);
    @(posedge clk);
    hold_rx <= 1'b1;
    repeat (HOLD_LEN) @(posedge clk);
    hold_rx <= 1'b0;
  end

  // run-away guard
  always @(posedge clk) begin
    cycles++;
    if (cycles > LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("simulation failed");
      $finish;
    end
  end

  logic [31:0] trk_left, trk_right;

  function automatic sample_t rand_sample(bit wild);
    sample_t s;
    int yawsel;
    if (wild || $urandom_range(9) == 0) begin
      s.left  = $urandom;
      s.right = $urandom;
      s.qw = 16'($urandom); s.qx = 16'($urandom); s.qy = 16'($urandom);
      s.qz = 16'($urandom);
      s.lv = 1'($urandom); s.rv = 1'($urandom);
      s.el = 24'($urandom);
    end else begin
      s.left  = trk_left + 32'($urandom_range(8000)) - 32'd4000;
      s.right = trk_right + 32'($urandom_range(8000)) - 32'd4000;
      s.lv = ($urandom_range(19) != 0);
      s.rv = ($urandom_range(19) != 0);
      // quaternion about z with random w and z magnitudes and signs, small roll/pitch noise
      yawsel = $urandom_range(3);
      s.qw = 16'($urandom_range(16384)) * ((yawsel & 1) ? -16'sd1 : 16'sd1);
      s.qz = 16'($urandom_range(16384)) * ((yawsel & 2) ? -16'sd1 : 16'sd1);
      s.qx = 16'($urandom_range(400)) - 16'd200;
      s.qy = 16'($urandom_range(400)) - 16'd200;
      case ($urandom_range(9))
        0:       s.el = '0;
        1:       s.el = 24'($urandom_range(3) + 1);
        default: s.el = 24'($urandom_range(40000, 1000));
      endcase
    end
    trk_left = s.left;
    trk_right = s.right;
    return s;
  endfunction

  task automatic write_radius(logic [15:0] v);
    cfg_ch.valid <= 1'b1;
    cfg_ch.data  <= v;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    cfg_ch.valid <= 1'b0;
    radius = v;
  endtask

  task automatic drain();
    while (sample_q.size() > 0 || sample_ch.valid || pose_q.size() > 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic push(logic [31:0] l, logic [31:0] r, logic lv, logic rv,
                      logic [15:0] w, logic [15:0] x, logic [15:0] y, logic [15:0] z,
                      logic [23:0] el);
    sample_t s;
    s = '{l, r, lv, rv, w, x, y, z, el};
    trk_left = l;
    trk_right = r;
    sample_q.push_back(s);
  endtask

  initial begin
    logic [15:0] radii [4];
    rst = 1'b1;
    errors = 0; results_seen = 0; zero_dt_seen = 0; cycles = 0;
    pressure_go = 1'b0;
    idle_mode = IDLE_NONE;
    trk_left = '0; trk_right = '0;
    radius = RADIUS_RST;
    prev_left = '0; prev_right = '0; prev_yaw = '0; head = '0;
    x_pos = '0; y_pos = '0;
    sample_ch.valid = 1'b0;
    sample_ch.wheel_left_pos = '0; sample_ch.wheel_right_pos = '0;
    sample_ch.left_valid = 1'b0; sample_ch.right_valid = 1'b0;
    sample_ch.quat_w = '0; sample_ch.quat_x = '0; sample_ch.quat_y = '0;
    sample_ch.quat_z = '0; sample_ch.elapsed_us = '0;
    result_ch.ready = 1'b0;
    cfg_ch.valid = 1'b0;
    cfg_ch.data = '0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    write_radius(16'd2163);

    // directed samples at the default radius
    push(32'h0000_4000, 32'h0000_4000, 1, 1, 16'sd16384, 0, 0, 0, 24'd10000);
    push(32'h0000_8000, 32'h0000_6000, 1, 1, 16'sd11585, 0, 0, 16'sd11585, 24'd10000);
    push(32'h0001_0000, 32'h0001_0000, 1, 1, 0, 0, 0, 16'sd16384, 24'd0);
    push(32'h0002_0000, 32'h0002_0000, 0, 1, 0, 0, 0, 16'sd16384, 24'd1);
    push(32'h0003_0000, 32'h0003_0000, 1, 0, 0, 0, 0, -16'sd16384, 24'hFFFFFF);
    // degenerate quaternion: both atan2 operands zero
    push(32'h0003_0000, 32'h0003_0000, 1, 1, 0, 0, 16'sd8192, 16'sd8192, 24'd5000);
    push(32'h0003_0000, 32'h0003_0000, 1, 1, 16'sd100, -16'sd100, 16'sd8192, 16'sd8192,
         24'd5000);
    // wheel angles wrap across the signed limits
    push(32'h7FFF_FFFF, 32'h8000_0000, 1, 1, 16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 16'sh7FFF,
         24'd1);
    push(32'h8000_0000, 32'h7FFF_FFFF, 1, 1, 16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000,
         24'd1);
    push(32'h7FFF_FFFF, 32'h7FFF_FFFF, 1, 1, 16'sh8000, 16'sh7FFF, 16'sh8000, 16'sh7FFF,
         24'd2);
    push(32'hFFFF_FFFF, 32'h0000_0000, 1, 1, 0, 16'sh7FFF, 16'sh7FFF, 0, 24'd3);
    push(32'h0000_0000, 32'hFFFF_FFFF, 0, 0, 16'sh8000, 0, 0, 16'sh7FFF, 24'd0);
    drain();

    radii = '{16'd65535, 16'd0, 16'($urandom), 16'd2163};
    for (int ph = 0; ph < 4; ph++) begin
      write_radius(radii[ph]);
      idle_mode = idle_mode_t'(ph);
      // large wheel steps to drive the position into saturation
      if (ph == 0)
        for (int k = 0; k < 6; k++)
          push(trk_left + 32'h7000_0000, trk_right + 32'h7000_0000, 1, 1,
               16'sd16384, 0, 0, 0, 24'd1);
      for (int k = 0; k < N_ITEMS / 4; k++) begin
        sample_q.push_back(rand_sample(k % 16 == 0));
        if (ph == 1 && k == 20) pressure_go = 1'b1;
      end
      drain();
    end

    $display("covered %0d result beats (%0d with zero elapsed time), radius 0/max/random,",
             results_seen, zero_dt_seen);
    $display("under no idling, source gaps, sink stalls, both, and one long sink hold-off");
    if (errors == 0) $display("simulation ok");
    else begin
      $display("%0d mismatching beats", errors);
      $display("simulation failed");
    end
    $finish;
  end

endmodule
`default_nettype wire

// ----- diff_drive_imu_odometry.f -----
sv/ddio_pkg.sv
sv/ddio_if.sv
sv/ddio_mac.sv
sv/ddio_cordic.sv
sv/ddio_div.sv
sv/diff_drive_imu_odometry.sv
tb/sv/tb_top.sv
